// ----- hw/rtl/swlz_pkg.sv -----
// Shared types and constants of the short-window LZ byte decoder.
package swlz_pkg;

  // History window and head region
  localparam int HIST_DEPTH = 128;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int LEN_W      = 32;
  localparam logic [7:0] HEAD_OFFSET = 8'hF0;

  // Token layout: flag, then 7-bit distance-1 and 4-bit length-2, or an 8-bit literal
  localparam int TOKEN_W = 12;
  localparam logic [3:0] LIT_BITS  = 4'd9;
  localparam logic [3:0] COPY_BITS = 4'd12;
  localparam logic [4:0] LEN_BIAS  = 5'd2;
  localparam logic [3:0] LAST_BIT  = 4'd7;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // Decoding mode of the current file
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PASS,
    MODE_HEAD,
    MODE_BITS
  } mode_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BIT,
    ST_CREAD,
    ST_CEMIT,
    ST_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic emit_direct;
    logic bit_step;
    logic copy_read;
    logic copy_emit;
    logic flush;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  hold_valid;
    logic  out_free;
    logic  bit_last;
    logic  bits_done;
    logic  step_lit;
    logic  step_copy;
    logic  emit_ends;
    logic  copy_last;
  } stat_t;

endpackage

// ----- hw/rtl/swlz_ctrl.sv -----
// Controller state machine that sequences loads, bit steps, copies and flushes.
module swlz_ctrl import swlz_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        unique case (stat.mode)
          MODE_IDLE: state_next = ST_IDLE;
          MODE_PASS,
          MODE_HEAD: begin
            if (stat.out_free) state_next = ST_FLUSH;
          end
          MODE_BITS: state_next = ST_BIT;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_BIT: begin
        if (stat.out_free) begin
          priority if (stat.step_copy) begin
            state_next = ST_CREAD;
          end else if ((stat.step_lit && stat.emit_ends) || stat.bit_last) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_BIT;
          end
        end
      end
      ST_CREAD: state_next = ST_CEMIT;
      ST_CEMIT: begin
        if (stat.out_free) begin
          priority if (stat.emit_ends) begin
            state_next = ST_FLUSH;
          end else if (stat.copy_last) begin
            state_next = stat.bits_done ? ST_FLUSH : ST_BIT;
          end else begin
            state_next = ST_CREAD;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.hold_valid || stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_START: begin
        cmd.emit_direct = stat.out_free &&
                          (stat.mode == MODE_PASS || stat.mode == MODE_HEAD);
      end
      ST_BIT:   cmd.bit_step  = stat.out_free;
      ST_CREAD: cmd.copy_read = 1'b1;
      ST_CEMIT: cmd.copy_emit = stat.out_free;
      ST_FLUSH: cmd.flush     = stat.hold_valid && stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/swlz_dp.sv -----
// Datapath: length register, token assembly, history memory and output staging.
module swlz_dp import swlz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [7:0]       in_byte,
  input  logic             in_first,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_eor,
  output logic             out_last
);

  logic [LEN_W-1:0]   out_len;
  logic [LEN_W-1:0]   produced;
  mode_t              mode;
  logic [7:0]         byte_reg;
  logic [3:0]         bit_cnt;
  logic [TOKEN_W-1:0] store;
  logic [3:0]         store_cnt;
  logic [HIST_AW-1:0] copy_dist;
  logic [4:0]         copy_left;
  logic [7:0]         rdata;
  logic [7:0]         hold_byte;
  logic               hold_last;
  logic               hold_valid;
  logic [7:0]         history [HIST_DEPTH];

  logic [TOKEN_W-1:0] store_step;
  logic [3:0]         cnt_step;
  logic               step_lit;
  logic               step_copy;
  logic               emit;
  logic [7:0]         emit_val;
  logic [LEN_W:0]     prod_inc;
  logic               emit_ends;
  logic               emit_last;
  logic               out_free;
  mode_t              load_mode;
  logic [LEN_W-1:0]   load_prod;
  logic [HIST_AW-1:0] rd_addr;

  // Token assembly for one bit, taken LSB-first from the held byte
  always_comb begin
    store_step = {store[TOKEN_W-2:0], byte_reg[bit_cnt[2:0]]};
    cnt_step   = store_cnt + 4'd1;
    step_lit   = (cnt_step == LIT_BITS) && !store_step[8];
    step_copy  = (cnt_step == COPY_BITS);
  end

  // Emission select and end-of-file tests
  always_comb begin
    emit      = cmd.emit_direct || (cmd.bit_step && step_lit) || cmd.copy_emit;
    prod_inc  = {1'b0, produced} + {{LEN_W{1'b0}}, 1'b1};
    emit_ends = prod_inc >= {1'b0, out_len};
    emit_last = prod_inc == {1'b0, out_len};
    out_free  = !out_valid || out_ready;
    priority if (cmd.copy_emit) begin
      emit_val = rdata;
    end else if (cmd.bit_step) begin
      emit_val = store_step[7:0];
    end else if (mode == MODE_HEAD) begin
      emit_val = byte_reg + HEAD_OFFSET;
    end else begin
      emit_val = byte_reg;
    end
  end

  // Mode chosen on load: restart on a first byte, stop once the length is reached
  always_comb begin
    load_mode = mode;
    load_prod = produced;
    if (in_first) begin
      load_prod = '0;
      load_mode = (out_len < LEN_W'(HIST_DEPTH)) ? MODE_PASS : MODE_HEAD;
    end
    if (load_mode != MODE_IDLE && load_prod >= out_len) load_mode = MODE_IDLE;
  end

  assign rd_addr = produced[HIST_AW-1:0] - copy_dist - HIST_AW'(1);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_len    <= '0;
      produced   <= '0;
      mode       <= MODE_IDLE;
      store      <= '0;
      store_cnt  <= '0;
      bit_cnt    <= '0;
      copy_left  <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) out_len <= cfg_wr_data;
      // Load the output register from the held item, or drain it
      if ((emit && hold_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        bit_cnt <= '0;
        mode    <= load_mode;
        if (in_first) begin
          produced  <= '0;
          store     <= '0;
          store_cnt <= '0;
        end
      end
      if (cmd.bit_step) begin
        bit_cnt <= bit_cnt + 4'd1;
        if (step_lit || step_copy) begin
          store     <= '0;
          store_cnt <= '0;
        end else begin
          store     <= store_step;
          store_cnt <= cnt_step;
        end
        if (step_copy) copy_left <= {1'b0, store_step[3:0]} + LEN_BIAS;
      end
      if (cmd.copy_emit) copy_left <= copy_left - 5'd1;
      // Advance count and mode, mark the new item as held
      if (emit) begin
        produced   <= prod_inc[LEN_W-1:0];
        hold_valid <= 1'b1;
        if (emit_ends) begin
          mode <= MODE_IDLE;
        end else if (mode == MODE_HEAD && prod_inc >= (LEN_W+1)'(HIST_DEPTH)) begin
          mode <= MODE_BITS;
        end
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) byte_reg <= in_byte;
    if (cmd.bit_step && step_copy) copy_dist <= store_step[10:4];
    if (emit) begin
      hold_byte <= emit_val;
      hold_last <= emit_last;
      if (hold_valid) begin
        out_byte <= hold_byte;
        out_last <= hold_last;
        out_eor  <= 1'b0;
      end
    end
    if (cmd.flush) begin
      out_byte <= hold_byte;
      out_last <= hold_last;
      out_eor  <= 1'b1;
    end
  end

  // History memory: write each decoded byte, registered read for copies
  always_ff @(posedge clk) begin
    if (emit) history[produced[HIST_AW-1:0]] <= emit_val;
    if (cmd.copy_read) rdata <= history[rd_addr];
  end

  // Status
  always_comb begin
    stat.mode       = mode;
    stat.hold_valid = hold_valid;
    stat.out_free   = out_free;
    stat.bit_last   = (bit_cnt == LAST_BIT);
    stat.bits_done  = (bit_cnt == BYTE_BITS);
    stat.step_lit   = step_lit;
    stat.step_copy  = step_copy;
    stat.emit_ends  = emit_ends;
    stat.copy_last  = (copy_left == 5'd1);
  end

endmodule

// ----- hw/rtl/short_window_lz_byte_decoder_unit.sv -----
// Top level of the short-window LZ byte decoder.
//
// Input stream: one compressed payload byte per item, starting after the 8-byte
// file header; s_tuser marks the first payload byte of a new file. The decoded
// length is written on cfg_wr_en/cfg_wr_data before a file starts.
// Output stream: one decoded byte per item; m_tlast flags the last item caused
// by an input item, m_tuser flags the final byte of the file.
// Short files pass bytes through; longer files emit 128 offset head bytes, then
// decode flag/literal and flag/distance/length tokens from a 128-byte history.
// Timing: an item is taken, then worked on alone. A pass-through or head byte is
// accepted, emitted and flushed. A bit-stream byte is accepted, then passes a start
// state, one step per bit and a flush, plus a history read and then an emit per copied
// byte; a file that ends part way skips the other bits. A decoded byte waits in a
// holding register until the next one is made or the flush.
// Reset clears the control state and the length register; the history is not
// cleared, since the head fills it before any copy reads it.
// A stalled receiver holds the output register; emits, bit steps and flushes wait until it frees.
module short_window_lz_byte_decoder_unit import swlz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,  // output_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] src_byte
  input  logic        s_tuser,      // [0] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [7:0] out_byte
  output logic        m_tlast,      // end_of_run
  output logic        m_tuser       // [0] last_out
);

  cmd_t  cmd;
  stat_t stat;

  swlz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  swlz_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_byte     (s_tdata),
    .in_first    (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_eor     (m_tlast),
    .out_last    (m_tuser)
  );

endmodule

// ----- sim/tb_short_window_lz_byte_decoder_unit.sv -----
// Self-checking testbench for the short-window LZ byte decoder unit.
module tb_short_window_lz_byte_decoder_unit import swlz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 220;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DIRECTED_LEN  = 152;
  localparam logic FLAG_LIT  = 1'b0;
  localparam logic FLAG_COPY = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } src_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       file_end;
  } dec_byte_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;       // [7:0] src_byte
  logic        s_tuser = 1'b0;     // [0] first_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;            // [7:0] out_byte
  logic        m_tlast;            // end_of_run
  logic        m_tuser;            // [0] last_out

  short_window_lz_byte_decoder_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

  // Stimulus and expectation stores
  src_item_t src_q[$];
  dec_byte_t want_bytes[$];
  bit        stream_bits[$];

  // Decoder shadow state
  logic [7:0]  hist [HIST_DEPTH];
  logic [15:0] tok_reg;
  logic [4:0]  tok_cnt;
  logic [31:0] made;
  mode_t       mode;
  logic [31:0] out_len;

  // Run bookkeeping
  logic idling = 1'b1;
  int   in_wait = 0;
  int   out_wait = 0;
  int   quiet = 0;
  int   errs = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_files = 0;
  int   n_live = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Append one decoded byte to the expectation store and the shadow history
  function automatic void emit_byte(input logic [7:0] v);
    dec_byte_t e;
    hist[made[HIST_AW-1:0]] = v;
    e.value    = v;
    e.run_end  = 1'b0;
    e.file_end = ((made + 32'd1) == out_len);
    want_bytes.push_back(e);
    made = made + 32'd1;
    if (made >= out_len) mode = MODE_IDLE;
  endfunction

  // Work out the decoded bytes caused by one accepted payload byte
  task automatic decode_src(input logic [7:0] src, input logic first);
    int          n0;
    logic [31:0] back;
    logic [31:0] cnt;
    logic [31:0] idx;
    dec_byte_t   tail;
    n0 = want_bytes.size();
    if (first) begin
      tok_reg = '0;
      tok_cnt = '0;
      made    = '0;
      mode    = (out_len < HIST_DEPTH) ? MODE_PASS : MODE_HEAD;
    end
    if (mode != MODE_IDLE && made >= out_len) mode = MODE_IDLE;
    case (mode)
      MODE_PASS: begin
        emit_byte(src);
      end
      MODE_HEAD: begin
        emit_byte(src + HEAD_OFFSET);
        if (mode == MODE_HEAD && made >= HIST_DEPTH) mode = MODE_BITS;
      end
      MODE_BITS: begin
        for (int i = 0; i < 8 && mode == MODE_BITS; i++) begin
          tok_reg = {tok_reg[14:0], src[i]};
          tok_cnt = tok_cnt + 5'd1;
          if (tok_cnt == LIT_BITS && tok_reg[8] == FLAG_LIT) begin
            emit_byte(tok_reg[7:0]);
            tok_reg = '0;
            tok_cnt = '0;
          end else if (tok_cnt >= COPY_BITS) begin
            back = {25'd0, tok_reg[10:4]} + 32'd1;
            cnt  = {28'd0, tok_reg[3:0]} + LEN_BIAS;
            tok_reg = '0;
            tok_cnt = '0;
            for (int unsigned k = 0; k < cnt && mode == MODE_BITS; k++) begin
              idx = made - back;
              emit_byte(hist[idx[HIST_AW-1:0]]);
            end
          end
        end
      end
      default: ;
    endcase
    // Mark the last byte of this item's run
    if (want_bytes.size() > n0) begin
      tail = want_bytes.pop_back();
      tail.run_end = 1'b1;
      want_bytes.push_back(tail);
    end
  endtask

  // Driver: present queued items, with random gaps between them
  always @(posedge clk) begin
    src_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_src(s_tdata, s_tuser);
        n_in++;
        in_wait = idling ? $urandom_range(0, 3) : 0;
      end
      if (!s_tvalid || s_tready) begin
        if (in_wait == 0 && src_q.size() > 0) begin
          it = src_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= it.data;
          s_tuser  <= it.first;
        end else begin
          s_tvalid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // Monitor: take decoded bytes with random stalls and check each field
  always @(posedge clk) begin
    dec_byte_t w;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (want_bytes.size() == 0) begin
          $error("unexpected result: out_byte %02h", m_tdata);
          errs++;
        end else begin
          w = want_bytes.pop_front();
          if (m_tdata !== w.value) begin
            $error("out_byte: expected %02h, got %02h", w.value, m_tdata);
            errs++;
          end
          if (m_tlast !== w.run_end) begin
            $error("end_of_run: expected %0b, got %0b", w.run_end, m_tlast);
            errs++;
          end
          if (m_tuser !== w.file_end) begin
            $error("last_out: expected %0b, got %0b", w.file_end, m_tuser);
            errs++;
          end
        end
        out_wait = idling ? $urandom_range(0, 3) : 0;
      end
      if (out_wait > 0) begin
        m_tready <= 1'b0;
        out_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("short_window_lz_byte_decoder_unit test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_src(input logic [7:0] data, input logic first, input bit live);
    src_item_t it;
    it.data  = data;
    it.first = first;
    src_q.push_back(it);
    if (live) n_live++;
  endtask

  // Hold until the block has been quiet with nothing owed for a while
  task automatic settle();
    int calm;
    calm = 0;
    while (calm < SETTLE_CYCLES) begin
      @(posedge clk);
      if (src_q.size() == 0 && !s_tvalid && want_bytes.size() == 0) calm++;
      else calm = 0;
    end
  endtask

  task automatic set_length(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    out_len = v;
  endtask

  task automatic start_file(input logic [31:0] len);
    settle();
    set_length(len);
    idling = ($urandom_range(0, 3) != 0);
    n_files++;
  endtask

  // Token stream: fields go in MSB-first
  task automatic put_field(input logic [7:0] v, input int width);
    for (int i = width - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic put_literal(input logic [7:0] v);
    put_field({7'd0, FLAG_LIT}, 1);
    put_field(v, 8);
  endtask

  task automatic put_copy(input int back, input int cnt);
    put_field({7'd0, FLAG_COPY}, 1);
    put_field(8'(back - 1), 7);
    put_field(8'(cnt - 2), 4);
  endtask

  // Pack the token bits LSB-first into payload bytes; pad with random bits
  task automatic pack_stream();
    logic [7:0] b;
    while (stream_bits.size() > 0) begin
      b = 8'($urandom_range(0, 255));
      for (int i = 0; i < 8; i++)
        if (stream_bits.size() > 0) b[i] = stream_bits.pop_front();
      push_src(b, 1'b0, 1'b1);
    end
  endtask

  // 128 head bytes; the first few hit the offset wrap
  task automatic push_head();
    logic [7:0] b;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      case (i)
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'h10;
        3:       b = 8'h0F;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_src(b, i == 0, 1'b1);
    end
  endtask

  task automatic push_ignored();
    int extra;
    extra = $urandom_range(1, 2);
    for (int i = 0; i < extra; i++) push_src(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic pass_file();
    int len;
    int cut;
    case ($urandom_range(0, 7))
      0:       len = HIST_DEPTH - 1;
      1:       len = 0;
      default: len = $urandom_range(1, 24);
    endcase
    start_file(len);
    // Sometimes abandon a run part way and restart with the same length
    if (len > 1 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, len - 1);
      for (int i = 0; i < cut; i++) push_src(8'($urandom_range(0, 255)), i == 0, 1'b1);
    end
    for (int i = 0; i < (len == 0 ? 1 : len); i++)
      push_src(8'($urandom_range(0, 255)), i == 0, 1'b1);
    if ($urandom_range(0, 2) == 0) push_ignored();
  endtask

  task automatic token_file();
    int len;
    int plan;
    int back;
    int cnt;
    len = ($urandom_range(0, 3) == 0) ? HIST_DEPTH : HIST_DEPTH + $urandom_range(1, 90);
    start_file(len);
    push_head();
    plan = HIST_DEPTH;
    while (plan < len) begin
      if ($urandom_range(0, 1) == 0) begin
        put_literal(8'($urandom_range(0, 255)));
        plan++;
      end else begin
        back = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, HIST_DEPTH);
        cnt  = $urandom_range(2, 17);
        put_copy(back, cnt);
        plan += cnt;
      end
    end
    pack_stream();
    if ($urandom_range(0, 2) == 0) push_ignored();
  endtask

  // Head followed by a random bit stream
  task automatic noise_file();
    logic [31:0] len;
    int          cnt;
    len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'(HIST_DEPTH + $urandom_range(0, 300));
    start_file(len);
    push_head();
    cnt = $urandom_range(4, 16);
    for (int i = 0; i < cnt; i++) push_src(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Change the length in the middle of a pass-through file
  task automatic retarget_file();
    int len;
    int head_cnt;
    int tail_cnt;
    len = $urandom_range(6, 30);
    start_file(len);
    head_cnt = $urandom_range(1, len - 1);
    for (int i = 0; i < head_cnt; i++) push_src(8'($urandom_range(0, 255)), i == 0, 1'b1);
    settle();
    set_length($urandom_range(0, 40));
    tail_cnt = $urandom_range(1, 6);
    for (int i = 0; i < tail_cnt; i++) push_src(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Sequence: directed cases, then random files
  initial begin
    int base;
    int pick;
    tok_reg = '0;
    tok_cnt = '0;
    made    = '0;
    mode    = MODE_IDLE;
    out_len = '0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any file start are dropped
    push_src(8'h00, 1'b0, 1'b0);
    push_src(8'hFF, 1'b0, 1'b0);

    // Zero length: the start byte yields nothing
    start_file(32'd0);
    push_src(8'hA5, 1'b1, 1'b1);
    push_src(8'h5A, 1'b0, 1'b0);

    // Short pass-through, then a byte after the file is done
    start_file(32'd3);
    push_src(8'h00, 1'b1, 1'b1);
    push_src(8'hFF, 1'b0, 1'b1);
    push_src(8'h5A, 1'b0, 1'b1);
    push_src(8'h77, 1'b0, 1'b0);

    // Length lowered below the bytes already produced
    start_file(32'd10);
    for (int i = 0; i < 4; i++) push_src(8'(8'h30 + i), i == 0, 1'b1);
    settle();
    set_length(32'd2);
    push_src(8'hC3, 1'b0, 1'b1);

    // Token stream: literal extremes, overlapping copy, farthest copy, overrun
    start_file(DIRECTED_LEN);
    push_head();
    put_literal(8'h00);
    put_literal(8'hFF);
    put_copy(1, 2);
    put_copy(HIST_DEPTH, 17);
    put_copy(5, 17);
    pack_stream();
    push_src(8'h81, 1'b0, 1'b0);

    // Largest length: the file never completes
    start_file(32'hFFFF_FFFF);
    push_src(8'hFF, 1'b1, 1'b1);
    push_src(8'h00, 1'b0, 1'b1);
    push_src(8'h80, 1'b0, 1'b1);

    base = n_live;
    while (n_live < base + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      pass_file();
      else if (pick < 7) token_file();
      else if (pick < 8) noise_file();
      else               retarget_file();
    end

    settle();
    $display("Ran %0d files (pass-through, head and token stream, length changes):", n_files);
    $display("  %0d payload items accepted, %0d decoded bytes checked", n_in, n_out);
    if (errs == 0) begin
      $display("short_window_lz_byte_decoder_unit test passed");
    end else begin
      $display("short_window_lz_byte_decoder_unit test failed");
    end
    $finish;
  end

endmodule
